[hw/rtl/lfkr_pkg.sv]
`default_nettype none

package lfkr_pkg;

  // line store size and widths
  localparam int LINE_CAPACITY = 256;
  localparam int FILL_W        = $clog2(LINE_CAPACITY + 1);
  localparam int POS_W         = 8;
  localparam int LEN_W         = 9;
  localparam int BYTE_W        = 8;

  // keyword store
  localparam int KW_MAX     = 16;
  localparam int KW_IDX_W   = $clog2(KW_MAX);
  localparam int KW_LEN_W   = $clog2(KW_MAX + 1);
  localparam int KW_HALF    = KW_MAX / 2;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KW_LOW  = 2'd0,
    CFG_KW_HIGH = 2'd1,
    CFG_KW_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  // keyword settings as seen by the framer
  typedef struct packed {
    logic [KW_MAX-1:0][BYTE_W-1:0] kw;
    logic [KW_LEN_W-1:0]           kw_len;
  } cfg_t;

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              route;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/line_framer_keyword_router_unit.sv]
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | rx_byte
// result    | out_valid / out_ready| kind, stored_byte, store_position,
//           |                      | line_length, to_command_route
// config    | cfg_we               | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready is high; an item passes through the
// input register, then the framer's line state update into the result register
// active-high sync reset clears line state, keyword bytes, valids; kw length 1
// a stalled result holds in the result register while the input register
// takes one more item if it is empty and then holds it with in_ready low

module line_framer_keyword_router_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [7:0]                       rx_byte,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [1:0]                       kind,
  output      logic [7:0]                       stored_byte,
  output      logic [7:0]                       store_position,
  output      logic [8:0]                       line_length,
  output      logic                             to_command_route,
  input  wire logic                             cfg_we,
  input  wire logic [lfkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfkr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lfkr_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           out_res;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;

  // stage one moves into the result register when that is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  lfkr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfkr_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign kind             = out_res.kind;
  assign stored_byte      = out_res.data;
  assign store_position   = out_res.pos;
  assign line_length      = out_res.len;
  assign to_command_route = out_res.route;

`ifndef SYNTH
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.kind == KIND_BYTE) || (out_res.kind == KIND_LINE) ||
                   (out_res.kind == KIND_OVERFLOW)))
    else $error("result kind out of range");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind == KIND_OVERFLOW)) |->
      ((out_res.data == '0) && (out_res.pos == '0) && (out_res.len == '0) &&
       !out_res.route))
    else $error("overflow item carries payload");

  a_line_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind == KIND_LINE)) |->
      ((out_res.len != '0) && (out_res.data == NEWLINE_BYTE)))
    else $error("line item without newline or length");
`endif

endmodule

`default_nettype wire

[hw/rtl/lfkr_cfg_regs.sv]
`default_nettype none

module lfkr_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lfkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfkr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output lfkr_pkg::cfg_t                        cfg
);
  import lfkr_pkg::*;

  logic [KW_MAX-1:0][BYTE_W-1:0] kw;
  logic [KW_LEN_W-1:0]           kw_len;
  logic [KW_LEN_W-1:0]           len_clamped;
  logic [4:0]                    len_raw;

  // length is clamped to 1..16 when written
  always_comb begin
    len_raw = cfg_wdata[4:0];
    if (len_raw == 5'd0) begin
      len_clamped = KW_LEN_W'(1);
    end else if (len_raw > 5'(KW_MAX)) begin
      len_clamped = KW_LEN_W'(KW_MAX);
    end else begin
      len_clamped = KW_LEN_W'(len_raw);
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kw     <= '0;
      kw_len <= KW_LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KW_LOW: begin
          for (int i = 0; i < KW_HALF; i++) begin
            kw[i] <= cfg_wdata[i*BYTE_W +: BYTE_W];
          end
        end
        CFG_KW_HIGH: begin
          for (int i = 0; i < KW_HALF; i++) begin
            kw[KW_HALF + i] <= cfg_wdata[i*BYTE_W +: BYTE_W];
          end
        end
        CFG_KW_LEN: begin
          kw_len <= len_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.kw     = kw;
  assign cfg.kw_len = kw_len;

endmodule

`default_nettype wire

[hw/rtl/lfkr_framer.sv]
`default_nettype none

module lfkr_framer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic [lfkr_pkg::BYTE_W-1:0]   rx_byte,
  input  wire lfkr_pkg::cfg_t                cfg,
  output lfkr_pkg::result_t                  res
);
  import lfkr_pkg::*;

  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   fill_count_next;
  logic [KW_LEN_W-1:0] match_position;
  logic [KW_LEN_W-1:0] match_position_next;
  logic                keyword_seen;
  logic                keyword_seen_next;

  logic [FILL_W-1:0]   fill_inc;
  logic [KW_LEN_W-1:0] mp_upd;
  logic                seen_upd;
  logic [BYTE_W-1:0]   kw_cur;

  assign kw_cur   = cfg.kw[match_position[KW_IDX_W-1:0]];
  assign fill_inc = fill_count + FILL_W'(1);

  // keyword matcher, simple restart without overlap
  always_comb begin
    mp_upd   = match_position;
    seen_upd = keyword_seen;
    if (!keyword_seen && (match_position < cfg.kw_len)) begin
      if (rx_byte == kw_cur) begin
        mp_upd = match_position + KW_LEN_W'(1);
        if (mp_upd == cfg.kw_len) begin
          seen_upd = 1'b1;
        end
      end else if (rx_byte == cfg.kw[0]) begin
        mp_upd = KW_LEN_W'(1);
      end else begin
        mp_upd = '0;
      end
    end
  end

  // result and next line state
  always_comb begin
    res                 = '0;
    res.kind            = KIND_BYTE;
    fill_count_next     = fill_count;
    match_position_next = match_position;
    keyword_seen_next   = keyword_seen;
    if (fill_count >= FILL_W'(LINE_CAPACITY)) begin
      res.kind            = KIND_OVERFLOW;
      fill_count_next     = '0;
      match_position_next = '0;
      keyword_seen_next   = 1'b0;
    end else begin
      res.data = rx_byte;
      res.pos  = fill_count[POS_W-1:0];
      if (rx_byte == NEWLINE_BYTE) begin
        res.kind            = KIND_LINE;
        res.len             = fill_inc[LEN_W-1:0];
        res.route           = seen_upd;
        fill_count_next     = '0;
        match_position_next = '0;
        keyword_seen_next   = 1'b0;
      end else begin
        fill_count_next     = fill_inc;
        match_position_next = mp_upd;
        keyword_seen_next   = seen_upd;
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      match_position <= '0;
      keyword_seen   <= 1'b0;
    end else if (fire) begin
      fill_count     <= fill_count_next;
      match_position <= match_position_next;
      keyword_seen   <= keyword_seen_next;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(LINE_CAPACITY))
    else $error("fill count above line capacity");

  a_seen_has_match: assert property (@(posedge clk) disable iff (rst)
    keyword_seen |-> (match_position != '0))
    else $error("keyword seen with empty match position");

  a_overflow_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && (res.kind == KIND_OVERFLOW)) |=> (fill_count == '0))
    else $error("overflow did not clear the line");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && (res.kind == KIND_LINE)) |=> ((fill_count == '0) && !keyword_seen))
    else $error("line end did not clear the state");
`endif

endmodule

`default_nettype wire
